>>> src/adaptive_binary_range_coder_defines.svh
// Assertion macros used by the checker of the adaptive binary range coder.
// Depends on nothing; the asserting module must have i_clk and i_rst_n in scope.
`ifndef ADAPTIVE_BINARY_RANGE_CODER_DEFINES_SVH
`define ADAPTIVE_BINARY_RANGE_CODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ABRC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ABRC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/abrc_pkg.sv
// Types and constants of the adaptive binary range coder.
// Used by the top level and by its port checker; depends on nothing.
package abrc_pkg;

    localparam int PROB_STORE_BITS = 16;
    localparam int PROB_USE_BITS   = 12;
    localparam int MIX_SHIFT       = PROB_STORE_BITS + 2 - PROB_USE_BITS;
    localparam int FAST_SHIFT      = 7;
    localparam int SLOW_SHIFT      = 8;
    localparam int WORD_BITS       = 16;
    localparam int LOW_BITS        = 32;
    localparam int COUNT_BITS      = 24;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = 2;

    localparam logic [COUNT_BITS-1:0] WORD_LIMIT_RESET = '1;

    localparam logic MODE_CODE  = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_CODE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WORD_LIMIT   = 2'd2;

    typedef struct packed {
        logic                 mode;
        logic                 bit_in;
        logic [WORD_BITS-1:0] prob_fast;
        logic [WORD_BITS-1:0] prob_slow;
        logic [WORD_BITS-1:0] code_word;
    } t_in_item;

    typedef struct packed {
        logic                 bit_out;
        logic [WORD_BITS-1:0] prob_fast_next;
        logic [WORD_BITS-1:0] prob_slow_next;
        logic [WORD_BITS-1:0] word_out;
        logic                 word_valid;
        logic                 word_taken;
        logic                 overflow;
        logic                 last;
    } t_out_item;

endpackage

>>> src/adaptive_binary_range_coder.sv
// Adaptive binary range coder: encoder or decoder step with two-rate probabilities.
// Depends on abrc_pkg for payload types and constants.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one transaction per
//   bit to code, or a flush. Output channel (o_out_valid / i_out_stall / o_out_data)
//   returns one result per coded bit, two for an encoder flush (top word of low,
//   then bottom word; the second has last set) and one for a decoder flush.
//   An accepted transaction lands in an input register; once the result queue has
//   room, the whole coding step (blend, renormalize, split with one 20x12 multiply,
//   compare, probability update) runs combinationally into a two-entry result queue.
//   While the receiver does not stall, throughput is one transaction per cycle; an
//   encoder flush needs two free queue entries. The rate is set by the
//   low/range/code register loop, closed once per cycle.
//   When the receiver stalls, results wait in the queue; the input register still
//   takes one more transaction, after which o_in_stall rises.
//   The user must write the configuration port (i_cfg_wr_en, i_cfg_index, i_cfg_data)
//   only while idle; the block does not enforce this. Writing initial_code also loads the decoder code register.
//   Synchronous reset clears the queue, low, word count and overflow flag, sets
//   range to all ones, code to zero, direction to encode and the word limit to max.
module adaptive_binary_range_coder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  abrc_pkg::t_in_item                   i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output abrc_pkg::t_out_item                  o_out_data,
    input  logic                                 i_cfg_wr_en,
    input  logic [abrc_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [abrc_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import abrc_pkg::*;

    localparam logic [PROB_USE_BITS-1:0] PE_MAX = '1;
    localparam logic [PROB_USE_BITS-1:0] PE_MIN = PROB_USE_BITS'(1);

    // rounded move of a probability towards the coded bit
    function automatic logic [WORD_BITS-1:0] prob_step(input logic [WORD_BITS-1:0] p,
                                                       input logic b, input int sh);
        logic signed [WORD_BITS+2:0] tgt;
        logic signed [WORD_BITS+2:0] rnd;
        logic signed [WORD_BITS+2:0] d;
        logic signed [WORD_BITS+2:0] q;
        tgt = b ? '0 : (WORD_BITS+3)'(1 << PROB_STORE_BITS);
        rnd = (WORD_BITS+3)'(1 << (sh - 1));
        d   = tgt - signed'({3'b000, p}) + rnd;
        q   = d >>> sh;
        return p + q[WORD_BITS-1:0];
    endfunction

    // configuration and coder state
    logic                  r_direction;
    logic [COUNT_BITS-1:0] r_word_limit;
    logic [LOW_BITS-1:0]   r_low, n_low;
    logic [LOW_BITS-1:0]   r_range, n_range;
    logic [LOW_BITS-1:0]   r_code, n_code;
    logic [COUNT_BITS-1:0] r_used, n_used;
    logic                  r_ovf, n_ovf;

    // input register
    logic                  r_in_valid;
    t_in_item              r_in;

    // result queue, entry 0 is the head
    t_out_item             r_q0, r_q1, n_q0, n_q1;
    logic [1:0]            r_cnt, n_cnt;

    logic                  pop, fire, in_acc;
    logic [1:0]            cnt_ap, need;
    t_out_item             res0, res1;

    // datapath
    logic                            is_flush, is_dec;
    logic [WORD_BITS+1:0]            mix;
    logic [WORD_BITS+1:0]            pe_raw;
    logic [PROB_USE_BITS-1:0]        pe;
    logic                            renorm, ok0, ok1;
    logic [COUNT_BITS-1:0]           used1;
    logic [LOW_BITS-1:0]             low1, rng_sh, rng1, code1, r2, mid, rng2;
    logic [LOW_BITS-PROB_USE_BITS-1:0] rq;
    logic                            bitv;

    always_comb begin
        is_flush = (r_in.mode == MODE_FLUSH);
        is_dec   = (r_direction == DIR_DECODE);

        mix    = {2'b00, r_in.prob_fast} + {1'b0, r_in.prob_fast, 1'b0}
               + {2'b00, r_in.prob_slow};
        pe_raw = mix >> MIX_SHIFT;
        if (pe_raw == '0) begin
            pe = PE_MIN;
        end else if (pe_raw > (WORD_BITS+2)'(PE_MAX)) begin
            pe = PE_MAX;
        end else begin
            pe = pe_raw[PROB_USE_BITS-1:0];
        end

        // word slots: first move uses the current count, a second one the updated count
        ok0   = (r_used < r_word_limit);
        used1 = ok0 ? r_used + COUNT_BITS'(1) : r_used;
        ok1   = (used1 < r_word_limit);

        renorm = (r_range[LOW_BITS-1:PROB_USE_BITS] == '0);
        low1   = renorm ? {r_low[WORD_BITS-1:0], {WORD_BITS{1'b0}}} : r_low;
        rng_sh = {r_range[WORD_BITS-1:0], {WORD_BITS{1'b1}}};
        if (renorm) begin
            rng1 = (rng_sh > ~low1) ? ~low1 : rng_sh;
        end else begin
            rng1 = r_range;
        end
        if (renorm && is_dec) begin
            code1 = {r_code[WORD_BITS-1:0], ok0 ? r_in.code_word : {WORD_BITS{1'b0}}};
        end else begin
            code1 = r_code;
        end

        rq   = rng1[LOW_BITS-1:PROB_USE_BITS];
        r2   = LOW_BITS'(rq) * LOW_BITS'(pe);
        mid  = low1 + r2;
        rng2 = rng1 - r2;
        bitv = is_dec ? (code1 >= mid) : r_in.bit_in;

        n_low   = r_low;
        n_range = r_range;
        n_code  = r_code;
        n_used  = r_used;
        n_ovf   = r_ovf;
        need    = 2'd1;

        res0 = '0;
        res1 = '0;
        res0.prob_fast_next = r_in.prob_fast;
        res0.prob_slow_next = r_in.prob_slow;
        res1.prob_fast_next = r_in.prob_fast;
        res1.prob_slow_next = r_in.prob_slow;

        if (is_flush && !is_dec) begin
            need            = 2'd2;
            res0.word_out   = ok0 ? r_low[LOW_BITS-1:WORD_BITS] : '0;
            res0.word_valid = ok0;
            res0.overflow   = r_ovf | ~ok0;
            res0.last       = 1'b0;
            res1.word_out   = ok1 ? r_low[WORD_BITS-1:0] : '0;
            res1.word_valid = ok1;
            res1.overflow   = r_ovf | ~ok0 | ~ok1;
            res1.last       = 1'b1;
            n_used          = ok1 ? used1 + COUNT_BITS'(1) : used1;
            n_ovf           = r_ovf | ~ok0 | ~ok1;
        end else if (is_flush) begin
            res0.overflow = r_ovf;
            res0.last     = 1'b1;
        end else begin
            res0.bit_out        = bitv;
            res0.prob_fast_next = prob_step(r_in.prob_fast, bitv, FAST_SHIFT);
            res0.prob_slow_next = prob_step(r_in.prob_slow, bitv, SLOW_SHIFT);
            res0.word_valid     = renorm && !is_dec && ok0;
            res0.word_out       = (renorm && !is_dec && ok0) ?
                                  r_low[LOW_BITS-1:WORD_BITS] : '0;
            res0.word_taken     = renorm && is_dec && ok0;
            res0.overflow       = r_ovf | (renorm & ~ok0);
            res0.last           = 1'b1;
            n_low   = bitv ? mid : low1;
            n_range = bitv ? rng2 : r2 - LOW_BITS'(1);
            n_code  = code1;
            n_used  = renorm ? used1 : r_used;
            n_ovf   = r_ovf | (renorm & ~ok0);
        end
    end

    // handshakes and result queue
    always_comb begin
        pop        = (r_cnt != 2'd0) && !i_out_stall;
        cnt_ap     = r_cnt - {1'b0, pop};
        fire       = r_in_valid && ((2'd2 - cnt_ap) >= need);
        o_in_stall = r_in_valid && !fire;
        in_acc     = i_in_valid && !o_in_stall;

        n_q0 = r_q0;
        n_q1 = r_q1;
        if (pop) begin
            n_q0 = r_q1;
        end
        if (fire) begin
            if (cnt_ap == 2'd0) begin
                n_q0 = res0;
                n_q1 = res1;
            end else begin
                n_q1 = res0;
            end
        end
        n_cnt = cnt_ap + (fire ? need : 2'd0);
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= DIR_ENCODE;
            r_word_limit <= WORD_LIMIT_RESET;
            r_low        <= '0;
            r_range      <= '1;
            r_code       <= '0;
            r_used       <= '0;
            r_ovf        <= 1'b0;
            r_in_valid   <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            r_in_valid <= in_acc || (r_in_valid && !fire);
            r_cnt      <= n_cnt;
            if (fire) begin
                r_low   <= n_low;
                r_range <= n_range;
                r_used  <= n_used;
                r_ovf   <= n_ovf;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_DIRECTION: begin
                        r_direction <= i_cfg_data[0];
                    end
                    CFG_INITIAL_CODE: begin
                        r_code <= i_cfg_data;
                    end
                    CFG_WORD_LIMIT: begin
                        r_word_limit <= i_cfg_data[COUNT_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end else if (fire) begin
                r_code <= n_code;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

endmodule

>>> src/abrc_checker.sv
// Port-level checker for the adaptive binary range coder, bound to the top level.
// Depends on abrc_pkg and adaptive_binary_range_coder_defines.svh.
`include "adaptive_binary_range_coder_defines.svh"

module abrc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    input  abrc_pkg::t_out_item                  o_out_data
);
    import abrc_pkg::*;

    logic out_acc;
    assign out_acc = o_out_valid && !i_out_stall;

    // hold a stalled result
    `ABRC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // a result never both emits and consumes a word
    `ABRC_ASSERT_NOW(a_word_dir, o_out_valid, !(o_out_data.word_valid && o_out_data.word_taken), "word emitted and taken together")

    // the first word of a flush is followed at once by its closing word
    `ABRC_ASSERT_NEXT(a_flush_pair, out_acc && !o_out_data.last, o_out_valid && o_out_data.last, "flush second word missing")

    // overflow stays raised until reset
    `ABRC_ASSERT_NEXT(a_ovf_sticky, out_acc && o_out_data.overflow, !o_out_valid || o_out_data.overflow, "overflow flag dropped")

endmodule

bind adaptive_binary_range_coder abrc_checker u_abrc_checker (.*);

>>> bench/range_coder_check_pkg.sv
// Scoreboard for the adaptive binary range coder bench: mirrors the coder state,
// predicts the results of each accepted input transaction and checks the results.
// Depends on abrc_pkg for the payload types, widths and codes.
package range_coder_check_pkg;

    import abrc_pkg::*;

    class range_coder_mirror;

        logic                  dir;
        logic [LOW_BITS-1:0]   init_code;
        logic [COUNT_BITS-1:0] limit;
        logic [LOW_BITS-1:0]   low;
        logic [LOW_BITS-1:0]   span;
        logic [LOW_BITS-1:0]   code;
        logic [COUNT_BITS-1:0] used;
        logic                  ovf;
        t_out_item             due_results[$];
        int                    mismatches;

        function new();
            dir        = DIR_ENCODE;
            init_code  = '0;
            limit      = WORD_LIMIT_RESET;
            low        = '0;
            span       = '1;
            code       = '0;
            used       = '0;
            ovf        = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_DIRECTION: begin
                    dir = data[0];
                end
                CFG_INITIAL_CODE: begin
                    init_code = data;
                    code      = data;
                end
                CFG_WORD_LIMIT: begin
                    limit = data[COUNT_BITS-1:0];
                end
                default: ;
            endcase
        endfunction

        // false when the stream is full; the overflow flag then sticks
        function bit claim_slot();
            if (used >= limit) begin
                ovf = 1'b1;
                return 1'b0;
            end
            used = used + 1'b1;
            return 1'b1;
        endfunction

        // move p towards the coded bit with rounding; floor division via arithmetic shift
        function logic [WORD_BITS-1:0] adapt(logic [WORD_BITS-1:0] p, logic b, int sh);
            int d;
            d = (b ? 0 : (1 << PROB_STORE_BITS)) - int'(p) + (1 << (sh - 1));
            return WORD_BITS'(int'(p) + (d >>> sh));
        endfunction

        function void code_item(t_in_item it);
            t_out_item                 r;
            logic [17:0]               mix;
            logic [PROB_USE_BITS-1:0]  est;
            logic [LOW_BITS-1:0]       split;
            logic [LOW_BITS-1:0]       mid;
            logic                      b;
            bit                        ok;
            r = '0;
            r.prob_fast_next = it.prob_fast;
            r.prob_slow_next = it.prob_slow;
            if (it.mode == MODE_FLUSH) begin
                if (dir == DIR_DECODE) begin
                    r.overflow = ovf;
                    r.last     = 1'b1;
                    due_results.push_back(r);
                    return;
                end
                ok = claim_slot();
                r.word_valid = ok;
                r.word_out   = ok ? low[31:16] : '0;
                r.overflow   = ovf;
                due_results.push_back(r);
                ok = claim_slot();
                r.word_valid = ok;
                r.word_out   = ok ? low[15:0] : '0;
                r.overflow   = ovf;
                r.last       = 1'b1;
                due_results.push_back(r);
                return;
            end

            // the blend tops out at 4095, so only the low clamp can bite
            mix = 18'(it.prob_fast) * 18'd3 + 18'(it.prob_slow);
            est = PROB_USE_BITS'(mix >> MIX_SHIFT);
            if (est == '0) begin
                est = PROB_USE_BITS'(1);
            end

            if (span < (1 << PROB_USE_BITS)) begin
                ok = claim_slot();
                if (dir == DIR_ENCODE) begin
                    if (ok) begin
                        r.word_out   = low[31:16];
                        r.word_valid = 1'b1;
                    end
                end else begin
                    code         = {code[15:0], (ok ? it.code_word : 16'h0000)};
                    r.word_taken = ok;
                end
                low  = low << 16;
                span = {span[15:0], 16'hFFFF};
                if (span > ~low) begin
                    span = ~low;
                end
            end

            split = (span >> PROB_USE_BITS) * est;
            mid   = low + split;
            span  = span - split;
            b     = (dir == DIR_DECODE) ? (code >= mid) : it.bit_in;
            if (b) begin
                low = mid;
            end else begin
                span = split - 1;
            end

            r.bit_out        = b;
            r.prob_fast_next = adapt(it.prob_fast, b, FAST_SHIFT);
            r.prob_slow_next = adapt(it.prob_slow, b, SLOW_SHIFT);
            r.overflow       = ovf;
            r.last           = 1'b1;
            due_results.push_back(r);
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t %s: want bit=%0d pf=%h ps=%h word=%h wv=%0d wt=%0d ovf=%0d last=%0d",
                         $time, what, want.bit_out, want.prob_fast_next, want.prob_slow_next,
                         want.word_out, want.word_valid, want.word_taken, want.overflow,
                         want.last);
                $display("    got  bit=%0d pf=%h ps=%h word=%h wv=%0d wt=%0d ovf=%0d last=%0d",
                         got.bit_out, got.prob_fast_next, got.prob_slow_next, got.word_out,
                         got.word_valid, got.word_taken, got.overflow, got.last);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                report("result with nothing due", '0, got);
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                report("result mismatch", want, got);
            end
        endfunction

    endclass

endpackage

>>> bench/tb_adaptive_binary_range_coder.sv
// Top of the adaptive binary range coder bench: directed and random encode/decode
// traffic with random idling on both channels, checked against range_coder_check_pkg.
// Depends on abrc_pkg, range_coder_check_pkg and the coder RTL.
module tb_adaptive_binary_range_coder;

    timeunit 1ns;
    timeprecision 1ps;

    import abrc_pkg::*;
    import range_coder_check_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 170;
    localparam int PHASE_COUNT  = 8;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_in_item                  in_data     = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_out_item                 o_out_data;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = CFG_DIRECTION;
    logic [CFG_DATA_BITS-1:0]  cfg_data    = '0;

    range_coder_mirror mirror;
    int                in_gap_pct    = 0;
    int                out_stall_pct = 0;
    int                stall_left    = 0;
    int                cycle_count   = 0;

    adaptive_binary_range_coder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL adaptive_binary_range_coder");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // check the result side, then decide the receiver stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            mirror.check_result(o_out_data);
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < out_stall_pct) begin
            stall_left = pick_gap() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_wr_en <= 1'b1;
        cfg_index   <= idx;
        cfg_data    <= data;
        @(posedge i_clk);
        mirror.write_reg(idx, data);
    endtask

    task automatic configure(logic dir, logic [LOW_BITS-1:0] code,
                             logic [COUNT_BITS-1:0] limit);
        write_reg(CFG_DIRECTION, {{(CFG_DATA_BITS-1){1'b0}}, dir});
        write_reg(CFG_INITIAL_CODE, code);
        write_reg(CFG_WORD_LIMIT, {{(CFG_DATA_BITS-COUNT_BITS){1'b0}}, limit});
        i_cfg_wr_en <= 1'b0;
    endtask

    // hold the transaction until accepted, then maybe idle
    task automatic send(t_in_item it);
        i_in_valid <= 1'b1;
        in_data    <= it;
        do @(posedge i_clk); while (o_in_stall);
        mirror.code_item(it);
        if ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic mode, logic b, logic [WORD_BITS-1:0] pf,
                               logic [WORD_BITS-1:0] ps, logic [WORD_BITS-1:0] cw);
        t_in_item it;
        it.mode      = mode;
        it.bit_in    = b;
        it.prob_fast = pf;
        it.prob_slow = ps;
        it.code_word = cw;
        send(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (mirror.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        int       kind;
        it.mode = ($urandom_range(0, 99) < 5) ? MODE_FLUSH : MODE_CODE;
        kind    = $urandom_range(0, 9);
        if (kind < 5) begin
            it.prob_fast = WORD_BITS'($urandom);
            it.prob_slow = WORD_BITS'($urandom);
        end else if (kind < 8) begin
            // settled model: slow estimate close to the fast one
            it.prob_fast = WORD_BITS'($urandom);
            it.prob_slow = it.prob_fast ^ WORD_BITS'($urandom_range(0, 255));
        end else begin
            it.prob_fast = $urandom_range(0, 1) ? 16'hFFFF - WORD_BITS'($urandom_range(0, 15))
                                                : WORD_BITS'($urandom_range(0, 15));
            it.prob_slow = $urandom_range(0, 1) ? 16'hFFFF - WORD_BITS'($urandom_range(0, 15))
                                                : WORD_BITS'($urandom_range(0, 15));
        end
        // draw most bits from the estimate so runs of likely symbols occur
        if ($urandom_range(0, 3) == 0) begin
            it.bit_in = 1'($urandom);
        end else begin
            it.bit_in = ($urandom_range(0, 65535) >= it.prob_fast);
        end
        it.code_word = WORD_BITS'($urandom);
        return it;
    endfunction

    initial begin
        logic                  dir;
        logic [LOW_BITS-1:0]   code;
        logic [COUNT_BITS-1:0] limit;
        mirror = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed encode: clamp ends of the blend, mixed rates, renormalization, flush
        configure(DIR_ENCODE, 32'h0000_0000, WORD_LIMIT_RESET);
        send_fields(MODE_CODE, 1'b0, 16'h0000, 16'h0000, 16'h0000);
        send_fields(MODE_CODE, 1'b1, 16'h0000, 16'h0000, 16'hFFFF);
        send_fields(MODE_CODE, 1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_fields(MODE_CODE, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_fields(MODE_CODE, 1'b0, 16'h0000, 16'hFFFF, 16'h5555);
        repeat (5) send_fields(MODE_CODE, 1'b1, 16'hFFFF, 16'hFFFF, 16'hAAAA);
        send_fields(MODE_CODE, 1'b0, 16'h8000, 16'h7FFF, 16'h0000);
        send_fields(MODE_FLUSH, 1'b1, 16'h1234, 16'hFEDC, 16'hFFFF);
        drain();

        // directed decode: renormalization consumes words, then a flush
        configure(DIR_DECODE, 32'hFFFF_FFFF, WORD_LIMIT_RESET);
        send_fields(MODE_CODE, 1'b0, 16'h0000, 16'h0000, 16'hFFFF);
        send_fields(MODE_CODE, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
        repeat (6) send_fields(MODE_CODE, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_fields(MODE_CODE, 1'b1, 16'h0001, 16'hFFFE, 16'h0000);
        send_fields(MODE_FLUSH, 1'b0, 16'hFFFF, 16'h0000, 16'h0000);
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            dir   = ph[0] ? DIR_DECODE : DIR_ENCODE;
            code  = $urandom;
            limit = WORD_LIMIT_RESET;
            case (ph)
                0: begin
                    code          = 32'h0000_0000;
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_gap_pct    = 20;
                    out_stall_pct = 20;
                end
                2: begin
                    code          = 32'hFFFF_FFFF;
                    in_gap_pct    = 60;
                    out_stall_pct = 5;
                end
                3: begin
                    code          = 32'hFFFF_FFFF;
                    in_gap_pct    = 5;
                    out_stall_pct = 50;
                end
                4: begin
                    code          = 32'h0000_0000;
                    in_gap_pct    = 30;
                    out_stall_pct = 30;
                end
                5: begin
                    // run into the word limit partway through the phase
                    limit         = mirror.used + COUNT_BITS'($urandom_range(2, 6));
                    in_gap_pct    = 15;
                    out_stall_pct = 15;
                end
                6: begin
                    limit         = mirror.used;
                    in_gap_pct    = 10;
                    out_stall_pct = 40;
                end
                default: begin
                    limit         = '0;
                    in_gap_pct    = 25;
                    out_stall_pct = 10;
                end
            endcase
            configure(dir, code, limit);
            repeat (PHASE_ITEMS) send(rand_item());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.due_results.size() == 0) begin
            $display("PASS adaptive_binary_range_coder");
        end else begin
            $display("FAIL adaptive_binary_range_coder");
        end
        $finish;
    end

endmodule
